// ----- design/touch_pattern_grid_recorder_macros.svh -----
// Assertion macros shared by the checker of the touch pattern grid recorder.
// No dependencies; the including module must have clk and arst_n in scope.
`ifndef TOUCH_PATTERN_GRID_RECORDER_MACROS_SVH
`define TOUCH_PATTERN_GRID_RECORDER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TPGR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpgr assertion failed");

// The consequent holds in the cycle after the antecedent.
`define TPGR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpgr assertion failed");

`endif

// ----- design/tpgr_pkg.sv -----
// Package of the touch pattern grid recorder: beat types, codes and defaults.
// No dependencies.
package tpgr_pkg;

	localparam int GRID_COLS_DEF   = 5;
	localparam int GRID_ROWS_DEF   = 5;
	localparam int COL_DIVIDER_DEF = 20;
	localparam int ROW_DIVIDER_DEF = 20;

	localparam int MAP_BITS   = 25;
	localparam int COORD_MAX  = 99;
	localparam int COORD_SPAN = 100;

	typedef enum logic [1:0] {
		KIND_REPORT = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		WID_PROXIMITY = 2'd0,
		WID_ACCEPT    = 2'd1,
		WID_CANCEL    = 2'd2,
		WID_TOUCHPAD  = 2'd3
	} widget_t;

	typedef enum logic [3:0] {
		EV_NONE           = 4'd0,
		EV_PROX_DETECTED  = 4'd1,
		EV_PROX_LOST      = 4'd2,
		EV_ACCEPT_PRESS   = 4'd3,
		EV_ACCEPT_RELEASE = 4'd4,
		EV_CANCEL_PRESS   = 4'd5,
		EV_CANCEL_RELEASE = 4'd6,
		EV_TOUCH_START    = 4'd7,
		EV_TOUCH_STOP     = 4'd8
	} event_code_t;

	typedef enum logic [0:0] {
		REG_EVENT_ENABLE = 1'd0
	} reg_index_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] widget;
		logic       active;
		logic [7:0] touch_x;
		logic [7:0] touch_y;
		logic [2:0] read_col;
		logic [2:0] read_row;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]          event_code;
		logic                pixel_value;
		logic                pattern_clear;
		logic [MAP_BITS-1:0] pattern_bits;
	} out_beat_t;

endpackage

// ----- design/touch_pattern_grid_recorder.sv -----
// Touch pattern grid recorder: widget edge events and a touch pattern bitmap.
// Depends on tpgr_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------
//  in      | input     | in_valid/in_stall  | in_beat_t
//  out     | output    | out_valid/out_stall| out_beat_t
//  config  | input     | APB, pready high   | event_enable
//
// One beat per cycle is sustained while the output is not stalled; each beat
// passes through the input register and then the result register.
// Reset clears the bitmap, the widget levels and the enables, and sets the
// clear flag. A stalled output holds its beat and the input register fills,
// after which in_stall rises until the output drains.
module touch_pattern_grid_recorder
	import tpgr_pkg::*;
#(
	parameter int GRID_COLS   = GRID_COLS_DEF,
	parameter int GRID_ROWS   = GRID_ROWS_DEF,
	parameter int COL_DIVIDER = COL_DIVIDER_DEF,
	parameter int ROW_DIVIDER = ROW_DIVIDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] COL_RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + COL_DIVIDER - 1) / COL_DIVIDER);
	localparam logic [RECIP_W-1:0] ROW_RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + ROW_DIVIDER - 1) / ROW_DIVIDER);
	localparam logic [3:0] COLS_L = 4'(GRID_COLS);
	localparam logic [3:0] ROWS_L = 4'(GRID_ROWS);
	localparam logic [5:0] COLS_M = 6'(GRID_COLS);
	localparam logic [5:0] MAP_L  = 6'(MAP_BITS);
	localparam logic [7:0] SPAN_L = 8'(COORD_SPAN);
	localparam logic [6:0] MAX_L  = 7'(COORD_MAX);

	logic                valid_s1;
	in_beat_t            item_s1;
	logic                valid_s2;
	out_beat_t           result_s2;
	logic                advance;

	logic [MAP_BITS-1:0] pattern_q;
	logic [3:0]          level_q;
	logic                clear_q;
	logic [3:0]          enable_q;

	logic [6:0]                 x_sat;
	logic [7:0]                 y_diff;
	logic [6:0]                 y_sat;
	logic [RECIP_W+6:0]         col_prod;
	logic [RECIP_W+6:0]         row_prod;
	logic [2:0]                 touch_col;
	logic [2:0]                 touch_row;
	logic [5:0]                 touch_idx;
	logic                       touch_in;
	logic [5:0]                 read_idx;
	logic                       read_in;
	logic [MAP_BITS-1:0]        read_shift;
	logic                       level_now;
	logic                       enabled;
	event_code_t                rise_code;
	event_code_t                fall_code;
	event_code_t                code;
	logic                       rose;
	logic                       pixel;
	logic [MAP_BITS-1:0]        pattern_next;
	logic [3:0]                 level_next;
	logic                       clear_next;
	logic                       cfg_write;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Touch coordinate clamping and grid cell mapping.
	assign x_sat  = (item_s1.touch_x >= SPAN_L) ? MAX_L : item_s1.touch_x[6:0];
	assign y_diff = SPAN_L - item_s1.touch_y;
	assign y_sat  = (item_s1.touch_y == 8'd0 || item_s1.touch_y > SPAN_L) ? MAX_L : y_diff[6:0];

	assign col_prod  = {{RECIP_W{1'b0}}, x_sat} * {7'd0, COL_RECIP};
	assign row_prod  = {{RECIP_W{1'b0}}, y_sat} * {7'd0, ROW_RECIP};
	assign touch_col = col_prod[RECIP_SHIFT +: 3];
	assign touch_row = row_prod[RECIP_SHIFT +: 3];
	assign touch_idx = {3'd0, touch_row} * COLS_M + {3'd0, touch_col};
	assign touch_in  = ({1'b0, touch_col} < COLS_L) && ({1'b0, touch_row} < ROWS_L)
		&& (touch_idx < MAP_L);

	assign read_idx   = {3'd0, item_s1.read_row} * COLS_M + {3'd0, item_s1.read_col};
	assign read_in    = ({1'b0, item_s1.read_col} < COLS_L)
		&& ({1'b0, item_s1.read_row} < ROWS_L) && (read_idx < MAP_L);
	assign read_shift = pattern_q >> read_idx;

	assign level_now = level_q[item_s1.widget];
	assign enabled   = enable_q[item_s1.widget];

	always_comb begin
		case (widget_t'(item_s1.widget))
			WID_PROXIMITY: begin
				rise_code = EV_PROX_DETECTED;
				fall_code = EV_PROX_LOST;
			end
			WID_ACCEPT: begin
				rise_code = EV_ACCEPT_PRESS;
				fall_code = EV_ACCEPT_RELEASE;
			end
			WID_CANCEL: begin
				rise_code = EV_CANCEL_PRESS;
				fall_code = EV_CANCEL_RELEASE;
			end
			default: begin
				rise_code = EV_TOUCH_START;
				fall_code = EV_TOUCH_STOP;
			end
		endcase
	end

	always_comb begin
		code         = EV_NONE;
		rose         = 1'b0;
		pixel        = 1'b0;
		pattern_next = pattern_q;
		level_next   = level_q;
		clear_next   = clear_q;
		case (kind_t'(item_s1.kind))
			KIND_REPORT: begin
				level_next[item_s1.widget] = item_s1.active;
				if (enabled && item_s1.active && !level_now) begin
					code = rise_code;
					rose = 1'b1;
				end else if (enabled && !item_s1.active && level_now) begin
					code = fall_code;
				end
				if (item_s1.widget == WID_TOUCHPAD) begin
					if (item_s1.active && touch_in) begin
						pattern_next = pattern_q | (MAP_BITS'(1) << touch_idx);
					end
					if (rose) begin
						clear_next = 1'b0;
					end
				end
			end
			KIND_CLEAR: begin
				pattern_next = '0;
				clear_next   = 1'b1;
			end
			KIND_READ: begin
				pixel = read_in && read_shift[0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			pattern_q <= '0;
			level_q   <= '0;
			clear_q   <= 1'b1;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				pattern_q <= pattern_next;
				level_q   <= level_next;
				clear_q   <= clear_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2.event_code    <= code;
			result_s2.pixel_value   <= pixel;
			result_s2.pattern_clear <= clear_next;
			result_s2.pattern_bits  <= pattern_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
		end else if (cfg_write && paddr[2] == REG_EVENT_ENABLE) begin
			enable_q <= pwdata[3:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EVENT_ENABLE) ? {28'd0, enable_q} : 32'd0;

endmodule

// ----- design/tpgr_checker.sv -----
// Port-level checker of the touch pattern grid recorder, bound to the top level.
// Depends on tpgr_pkg and touch_pattern_grid_recorder_macros.svh.
`include "touch_pattern_grid_recorder_macros.svh"

module tpgr_checker
	import tpgr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	// A held beat keeps its payload until it is taken.
	`TPGR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// A touch start can only be reported with touchpad events enabled, which drops the flag.
	`TPGR_ASSERT_NOW(a_start_drops_clear, out_valid && out_data.event_code == EV_TOUCH_START,
		!out_data.pattern_clear)

	// A set cell can only be read back from a non-empty bitmap.
	`TPGR_ASSERT_NOW(a_pixel_needs_bits, out_valid && out_data.pixel_value,
		out_data.pattern_bits != '0)

	// Event codes stay within the defined set.
	`TPGR_ASSERT_NOW(a_code_range, out_valid, out_data.event_code <= EV_TOUCH_STOP)

endmodule

bind touch_pattern_grid_recorder tpgr_checker u_tpgr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
